>>> src/input_action_mapper_defines.svh
// Assertion macros for the input action mapper.
// Included by files that carry concurrent assertions; needs clock and reset in scope.
`ifndef INPUT_ACTION_MAPPER_DEFINES_SVH
`define INPUT_ACTION_MAPPER_DEFINES_SVH

`ifndef ASSERT_OFF
`define IAM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define IAM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define IAM_ASSERT_IMP(lbl, ante, cons, msg)
`define IAM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/iam_pkg.sv
// Shared types and constants for the input action mapper.
// Used by iam_ctrl, iam_datapath and input_action_mapper; no dependencies.
package iam_pkg;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_REBIND  = 2'd1,
      OP_INSTALL = 2'd2,
      OP_HELD    = 2'd3
   } opcode_type;

   localparam logic [1:0] RSP_DONE    = 2'd0;
   localparam logic [1:0] RSP_RANGE   = 2'd1;
   localparam logic [1:0] RSP_REFUSED = 2'd2;

   typedef enum logic [1:0] {
      SWP_CLEAR,
      SWP_REBIND,
      SWP_INSTALL,
      SWP_HELD
   } sweep_mode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [2:0]  group;
      logic [3:0]  slot;
      logic [1:0]  device;
      logic [15:0] key_code;
      logic        frame_last;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        frame_done;
      logic [13:0] edges;
   } rsp_item_type;

   typedef struct packed {
      logic           capture;
      logic           step;
      sweep_mode_type mode;
      logic           load_we;
      logic           activate;
      logic           emit;
   } ctrl_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       range_err;
      logic       reserved;
      logic       group_match;
      logic       sweep_last;
   } dp_status_type;

   function automatic logic [15:0] default_key(input logic [4:0] idx);
      logic [15:0] key;
      case (idx)
         5'd0:    key = 16'd203;
         5'd1:    key = 16'd205;
         5'd2:    key = 16'd200;
         5'd3:    key = 16'd208;
         5'd4:    key = 16'd18;
         5'd5:    key = 16'd19;
         5'd6:    key = 16'd32;
         5'd7:    key = 16'd33;
         5'd8:    key = 16'd29;
         5'd9:    key = 16'd57;
         5'd10:   key = 16'd34;
         5'd11:   key = 16'd35;
         5'd12:   key = 16'd42;
         5'd13:   key = 16'd15;
         default: key = 16'd0;
      endcase
      return key;
   endfunction

endpackage

>>> src/iam_ctrl.sv
// Sequencer for the input action mapper: clearing pass, decode, sweeps, response.
// Depends on iam_pkg for command and status types.
module iam_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  iam_pkg::dp_status_type sts,
   output iam_pkg::ctrl_cmd_type  cmd
);
   import iam_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SWEEP,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type      state_ff, state_in;
   sweep_mode_type mode_ff, mode_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.mode     = mode_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.step = 1'b1;
            cmd.mode = SWP_CLEAR;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.op)
               OP_LOAD: begin
                  cmd.load_we = !sts.range_err;
                  state_in    = S_FINISH;
               end
               OP_REBIND: begin
                  if (sts.range_err || sts.reserved) begin
                     state_in = S_FINISH;
                  end else begin
                     mode_in  = SWP_REBIND;
                     state_in = S_SWEEP;
                  end
               end
               OP_INSTALL: begin
                  if (sts.range_err) begin
                     state_in = S_FINISH;
                  end else begin
                     mode_in  = SWP_INSTALL;
                     state_in = S_SWEEP;
                  end
               end
               OP_HELD: begin
                  mode_in  = SWP_HELD;
                  state_in = S_SWEEP;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_SWEEP: begin
            cmd.step = 1'b1;
            if (sts.sweep_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (mode_ff == SWP_REBIND && sts.group_match) begin
               mode_in  = SWP_INSTALL;
               state_in = S_SWEEP;
            end else begin
               cmd.activate = (mode_ff == SWP_INSTALL);
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         mode_ff      <= SWP_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/iam_datapath.sv
// Datapath of the input action mapper: binding store, live table, sweep counters,
// held accumulator and response register. Depends on iam_pkg.
module iam_datapath #(
   parameter int GROUPS    = 8,
   parameter int SLOTS     = 14,
   parameter int DEVICES   = 3,
   parameter int CODE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  iam_pkg::req_item_type req_data,
   input  logic                  csr_wr_en,
   input  logic [13:0]           csr_wr_data,
   input  iam_pkg::ctrl_cmd_type  cmd,
   output iam_pkg::dp_status_type sts,
   output iam_pkg::rsp_item_type  rsp_data
);
   import iam_pkg::*;

   localparam int CW          = (CODE_BITS < 16) ? CODE_BITS : 16;
   localparam int STORE_DEPTH = GROUPS * SLOTS * DEVICES;
   localparam int LIVE_DEPTH  = SLOTS * DEVICES;
   localparam int SA_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LA_W        = (LIVE_DEPTH > 1) ? $clog2(LIVE_DEPTH) : 1;
   localparam int SW          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DW          = (DEVICES > 1) ? $clog2(DEVICES) : 1;

   logic [CW-1:0] store_mem [STORE_DEPTH];
   logic [CW-1:0] live_mem  [LIVE_DEPTH];

   req_item_type   item_ff;
   logic [13:0]    repeat_mask_ff;
   logic [SA_W-1:0] lin_ff;
   logic [SW-1:0]  slot_ff;
   logic [DW-1:0]  dev_ff;
   logic           p_valid_ff;
   sweep_mode_type p_mode_ff;
   logic [SW-1:0]  p_slot_ff;
   logic [SA_W-1:0] p_store_wa_ff;
   logic [LA_W-1:0] p_live_wa_ff;
   logic [CW-1:0]  store_rd_ff;
   logic [CW-1:0]  live_rd_ff;
   logic [SLOTS-1:0] held_ff;
   logic [SLOTS-1:0] last_held_ff;
   logic           act_valid_ff;
   logic [2:0]     act_group_ff;
   rsp_item_type   rsp_ff, rsp_in;

   logic [CW-1:0]  code_w;
   logic           g_ok, s_ok, d_ok, code_nz, hit, frame_end;
   logic [31:0]    store_ra32, load_wa32, live_ra32, live_wa32, dev32, edges32;
   logic [15:0]    def_key;
   logic           st_we, lv_we;
   logic [SA_W-1:0] st_wa;
   logic [CW-1:0]  st_wd, lv_wd;
   logic [LA_W-1:0] lv_wa;

   assign code_w  = item_ff.key_code[CW-1:0];
   assign g_ok    = 32'(item_ff.group) < 32'(GROUPS);
   assign s_ok    = 32'(item_ff.slot) < 32'(SLOTS);
   assign d_ok    = 32'(item_ff.device) < 32'(DEVICES);
   assign code_nz = (code_w != '0);

   always_comb begin
      dev32      = (cmd.mode == SWP_INSTALL) ? 32'(dev_ff) : 32'(item_ff.device);
      store_ra32 = (32'(item_ff.group) * 32'(SLOTS) + 32'(slot_ff)) * 32'(DEVICES) + dev32;
      load_wa32  = (32'(item_ff.group) * 32'(SLOTS) + 32'(item_ff.slot)) * 32'(DEVICES)
                   + 32'(item_ff.device);
      live_ra32  = d_ok ? 32'(slot_ff) * 32'(DEVICES) + 32'(item_ff.device) : 32'd0;
      live_wa32  = 32'(slot_ff) * 32'(DEVICES) + 32'(dev_ff);
      def_key    = default_key(5'(slot_ff));
   end

   // status towards the sequencer
   always_comb begin
      sts.op          = item_ff.opcode;
      sts.reserved    = (code_w == CW'(0)) || (code_w == CW'(1)) || (code_w == CW'(4));
      sts.group_match = act_valid_ff && (act_group_ff == item_ff.group);
      case (item_ff.opcode)
         OP_LOAD, OP_REBIND: sts.range_err = !(g_ok && s_ok && d_ok);
         OP_INSTALL:         sts.range_err = !g_ok;
         default:            sts.range_err = 1'b0;
      endcase
      case (cmd.mode)
         SWP_CLEAR:   sts.sweep_last = (lin_ff == SA_W'(STORE_DEPTH - 1));
         SWP_INSTALL: sts.sweep_last = (slot_ff == SW'(SLOTS - 1)) &&
                                       (dev_ff == DW'(DEVICES - 1));
         default:     sts.sweep_last = (slot_ff == SW'(SLOTS - 1));
      endcase
   end

   // sweep counters: advance while stepping, otherwise hold at zero
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff  <= '0;
         slot_ff <= '0;
         dev_ff  <= '0;
      end else if (cmd.step) begin
         case (cmd.mode)
            SWP_CLEAR, SWP_INSTALL: begin
               lin_ff <= lin_ff + SA_W'(1);
               if (dev_ff == DW'(DEVICES - 1)) begin
                  dev_ff  <= '0;
                  slot_ff <= (slot_ff == SW'(SLOTS - 1)) ? '0 : slot_ff + SW'(1);
               end else begin
                  dev_ff <= dev_ff + DW'(1);
               end
            end
            default: begin
               slot_ff <= slot_ff + SW'(1);
            end
         endcase
      end else begin
         lin_ff  <= '0;
         slot_ff <= '0;
         dev_ff  <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= cmd.step && (cmd.mode != SWP_CLEAR);
      end
   end

   always_ff @(posedge clock) begin
      p_mode_ff     <= cmd.mode;
      p_slot_ff     <= slot_ff;
      p_store_wa_ff <= store_ra32[SA_W-1:0];
      p_live_wa_ff  <= live_wa32[LA_W-1:0];
      if (cmd.capture) item_ff <= req_data;
   end

   // write port selection
   always_comb begin
      st_we = 1'b0;
      st_wa = lin_ff;
      st_wd = '0;
      if (cmd.step && cmd.mode == SWP_CLEAR) begin
         st_we = 1'b1;
      end else if (cmd.load_we) begin
         st_we = 1'b1;
         st_wa = load_wa32[SA_W-1:0];
         st_wd = code_w;
      end else if (p_valid_ff && p_mode_ff == SWP_REBIND) begin
         st_wa = p_store_wa_ff;
         if (32'(p_slot_ff) == 32'(item_ff.slot)) begin
            st_we = 1'b1;
            st_wd = code_w;
         end else begin
            st_we = (store_rd_ff == code_w);
         end
      end

      lv_we = 1'b0;
      lv_wa = lin_ff[LA_W-1:0];
      lv_wd = (dev_ff == '0) ? def_key[CW-1:0] : '0;
      if (cmd.step && cmd.mode == SWP_CLEAR) begin
         lv_we = 32'(lin_ff) < 32'(LIVE_DEPTH);
      end else if (p_valid_ff && p_mode_ff == SWP_INSTALL) begin
         lv_we = 1'b1;
         lv_wa = p_live_wa_ff;
         lv_wd = store_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_wa] <= st_wd;
      store_rd_ff <= store_mem[store_ra32[SA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (lv_we) live_mem[lv_wa] <= lv_wd;
      live_rd_ff <= live_mem[live_ra32[LA_W-1:0]];
   end

   assign hit = p_valid_ff && (p_mode_ff == SWP_HELD) && d_ok && code_nz &&
                (live_rd_ff == code_w);
   assign frame_end = (item_ff.opcode == OP_HELD) && item_ff.frame_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         last_held_ff <= '0;
      end else if (cmd.emit && frame_end) begin
         last_held_ff <= held_ff;
         held_ff      <= '0;
      end else if (hit) begin
         held_ff[p_slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff   <= 1'b0;
         act_group_ff   <= '0;
         repeat_mask_ff <= '0;
      end else begin
         if (cmd.activate) begin
            act_valid_ff <= 1'b1;
            act_group_ff <= item_ff.group;
         end
         if (csr_wr_en) repeat_mask_ff <= csr_wr_data;
      end
   end

   always_comb begin
      edges32 = 32'(held_ff) & ~(32'(repeat_mask_ff) & 32'(last_held_ff));
      rsp_in  = '0;
      case (item_ff.opcode)
         OP_LOAD, OP_INSTALL: rsp_in.status = sts.range_err ? RSP_RANGE : RSP_DONE;
         OP_REBIND: begin
            if (sts.range_err) rsp_in.status = RSP_RANGE;
            else if (sts.reserved) rsp_in.status = RSP_REFUSED;
            else rsp_in.status = RSP_DONE;
         end
         default: begin
            rsp_in.status     = RSP_DONE;
            rsp_in.frame_done = item_ff.frame_last;
            rsp_in.edges      = item_ff.frame_last ? edges32[13:0] : 14'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> src/input_action_mapper.sv
// Input action mapper: maps device codes held in a frame to action bits.
// Channels: req (valid/ready, req_item_type) carries load, rebind, install and
// held-code items; rsp (valid/ready, rsp_item_type) returns one result per item;
// csr_wr_en/csr_wr_data write repeat_mask at once; the user must write it only
// while idle, and the block does not enforce this. One item is in work at a time;
// an item is taken while a finished result still waits on rsp, and the next
// transfer can be taken in the same cycle that rsp_valid rises. From transfer to
// rsp_valid an item passes decode, a sweep and drain where needed, and finish:
//   load, refused or out-of-range items: no sweep
//   held code: one live-table read per slot; install: one store read per entry
//   rebind: one store read per slot, plus an install sweep when the group is installed.
// Each sweep reads one entry at a time through the single read port of its memory.
// After reset a clearing pass over all GROUPS*SLOTS*DEVICES entries (336 by
// default) zeroes the binding store and loads the default keyboard codes; req_ready
// is low meanwhile. When rsp_ready is low the result is held in the output
// register, and the next result waits until it is taken.
// Depends on iam_pkg, iam_ctrl, iam_datapath and input_action_mapper_defines.svh.
`include "input_action_mapper_defines.svh"

module input_action_mapper #(
   parameter int GROUPS    = 8,
   parameter int SLOTS     = 14,
   parameter int DEVICES   = 3,
   parameter int CODE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  iam_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output iam_pkg::rsp_item_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [13:0]           csr_wr_data
);
   import iam_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   iam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iam_datapath #(
      .GROUPS    (GROUPS),
      .SLOTS     (SLOTS),
      .DEVICES   (DEVICES),
      .CODE_BITS (CODE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

   `IAM_ASSERT_IMP(a_ready_quiet, req_ready, !cmd.step && !cmd.emit, "ready while busy")
   `IAM_ASSERT_IMP(a_emit_free, cmd.emit, !rsp_valid || rsp_ready, "result overwritten")
   `IAM_ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready, "second transfer taken")
   `IAM_ASSERT_NXT(a_emit_valid, cmd.emit, rsp_valid, "result not presented")

endmodule

>>> sim/tb_input_action_mapper.sv
// Self-checking bench for input_action_mapper: binding loads, rebinds, installs and
// held-code frames, checked against a scoreboard that mirrors the bindings and live table.
// Needs iam_pkg and the input_action_mapper RTL.
`timescale 1ns / 100ps

module tb_input_action_mapper;
   import iam_pkg::*;

   localparam int GROUP_COUNT  = 8;
   localparam int SLOT_COUNT   = 14;
   localparam int DEVICE_COUNT = 3;

   localparam bit [15:0] CODE_NONE   = 16'd0;
   localparam bit [15:0] CODE_RSV_LO = 16'd1;
   localparam bit [15:0] CODE_RSV_HI = 16'd4;

   localparam bit [15:0] DEFAULT_KEYS [SLOT_COUNT] = '{
      16'd203, 16'd205, 16'd200, 16'd208, 16'd18, 16'd19, 16'd32,
      16'd33, 16'd29, 16'd57, 16'd34, 16'd35, 16'd42, 16'd15
   };

   class action_map_scoreboard;
      bit [15:0]    bindings [GROUP_COUNT][SLOT_COUNT][DEVICE_COUNT];
      bit [15:0]    live [SLOT_COUNT][DEVICE_COUNT];
      bit           installed;
      bit [2:0]     installed_group;
      bit [13:0]    held_now;
      bit [13:0]    held_prev;
      bit [13:0]    repeat_mask;
      rsp_item_type awaited_outcomes [$];
      int           errors;
      int           transfers;
      int           checked;
      int           frames;
      int           rejects;

      function new();
         foreach (bindings[g, s, d]) bindings[g][s][d] = '0;
         foreach (live[s, d]) live[s][d] = (d == 0) ? DEFAULT_KEYS[s] : '0;
         installed = 1'b0;
         installed_group = '0;
         held_now = '0;
         held_prev = '0;
         repeat_mask = '0;
         errors = 0;
         transfers = 0;
         checked = 0;
         frames = 0;
         rejects = 0;
      endfunction

      function void install(bit [2:0] g);
         foreach (live[s, d]) live[s][d] = bindings[g][s][d];
         installed = 1'b1;
         installed_group = g;
      endfunction

      function void note_transfer(req_item_type it);
         rsp_item_type r;
         bit           out_of_range;
         r = '0;
         out_of_range = int'(it.group) >= GROUP_COUNT || int'(it.slot) >= SLOT_COUNT ||
                        int'(it.device) >= DEVICE_COUNT;
         transfers++;
         case (it.opcode)
            OP_LOAD: begin
               if (out_of_range) r.status = RSP_RANGE;
               else bindings[it.group][it.slot][it.device] = it.key_code;
            end
            OP_REBIND: begin
               if (out_of_range) begin
                  r.status = RSP_RANGE;
               end else if (it.key_code == CODE_NONE || it.key_code == CODE_RSV_LO ||
                            it.key_code == CODE_RSV_HI) begin
                  r.status = RSP_REFUSED;
               end else begin
                  for (int a = 0; a < SLOT_COUNT; a++)
                     if (a != int'(it.slot) && bindings[it.group][a][it.device] == it.key_code)
                        bindings[it.group][a][it.device] = '0;
                  bindings[it.group][it.slot][it.device] = it.key_code;
                  if (installed && installed_group == it.group) install(it.group);
               end
            end
            OP_INSTALL: begin
               if (int'(it.group) >= GROUP_COUNT) r.status = RSP_RANGE;
               else install(it.group);
            end
            default: begin
               if (it.key_code != CODE_NONE && int'(it.device) < DEVICE_COUNT)
                  for (int a = 0; a < SLOT_COUNT; a++)
                     if (live[a][it.device] == it.key_code) held_now[a] = 1'b1;
               if (it.frame_last) begin
                  r.frame_done = 1'b1;
                  r.edges = held_now & ~(repeat_mask & held_prev);
                  held_prev = held_now;
                  held_now = '0;
                  frames++;
               end
            end
         endcase
         if (r.status != RSP_DONE) rejects++;
         awaited_outcomes.push_back(r);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type exp;
         if (awaited_outcomes.size() == 0) begin
            $error("unexpected result: status %0d frame_done %0b edges %h",
                   got.status, got.frame_done, got.edges);
            errors++;
            return;
         end
         exp = awaited_outcomes.pop_front();
         checked++;
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
         end
         if (got.frame_done !== exp.frame_done) begin
            $error("frame_done: expected %0b, got %0b", exp.frame_done, got.frame_done);
            errors++;
         end
         if (got.edges !== exp.edges) begin
            $error("edges: expected %h, got %h", exp.edges, got.edges);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   logic         csr_wr_en;
   logic [13:0]  csr_wr_data;

   action_map_scoreboard board;
   int send_idle_pct;
   int rsp_stall_pct;
   int hold_left;
   int masks_written;

   input_action_mapper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Timed out with %0d results outstanding", board.awaited_outcomes.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // hold rsp_ready low while hold_left counts down, otherwise stall at the phase rate
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= (int'($urandom_range(99)) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   function automatic req_item_type pack_item(opcode_type op, bit [2:0] g, bit [3:0] s,
                                              bit [1:0] d, bit [15:0] code, bit last);
      req_item_type it;
      it.opcode = op;
      it.group = g;
      it.slot = s;
      it.device = d;
      it.key_code = code;
      it.frame_last = last;
      return it;
   endfunction

   function automatic bit [15:0] pick_code();
      case ($urandom_range(9))
         0: return CODE_NONE;
         1: return CODE_RSV_LO;
         2: return CODE_RSV_HI;
         3, 4: return 16'($urandom_range(2, 9));
         5: return 16'hFFFF;
         6: return DEFAULT_KEYS[$urandom_range(SLOT_COUNT - 1)];
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly well-formed traffic with bound codes, some raw noise
   function automatic req_item_type random_item();
      req_item_type it;
      logic [27:0]  raw;
      int           sel;
      int           pick;
      sel = $urandom_range(99);
      raw = 28'($urandom);
      it = raw;
      if (sel < 5) return it;
      if (sel < 60) begin
         it.opcode = OP_HELD;
         it.device = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(DEVICE_COUNT - 1));
         pick = $urandom_range(9);
         if (pick < 6 && int'(it.device) < DEVICE_COUNT)
            it.key_code = board.live[$urandom_range(SLOT_COUNT - 1)][it.device];
         else if (pick == 6)
            it.key_code = CODE_NONE;
         it.frame_last = ($urandom_range(2) == 0);
      end else if (sel < 90) begin
         it.opcode = (sel < 72) ? OP_LOAD : OP_REBIND;
         it.slot = ($urandom_range(11) == 0) ? 4'($urandom_range(14, 15))
                                             : 4'($urandom_range(SLOT_COUNT - 1));
         it.device = ($urandom_range(11) == 0) ? 2'd3 : 2'($urandom_range(DEVICE_COUNT - 1));
         it.key_code = pick_code();
      end else begin
         it.opcode = OP_INSTALL;
      end
      return it;
   endfunction

   task automatic send_item(input req_item_type it);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      board.note_transfer(it);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.awaited_outcomes.size() != 0);
   endtask

   task automatic write_mask(input bit [13:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      board.repeat_mask = value;
      masks_written++;
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                            input bit [13:0] mask, input int hold);
      write_mask(mask);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (hold > 0) hold_left = hold;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 49) wait_drained();
         send_item(random_item());
      end
      wait_drained();
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left = 0;
      masks_written = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // wait out the clearing pass
      do @(posedge clock); while (!req_ready);
      write_mask(14'h0000);

      send_item(pack_item(OP_HELD, 3'd0, 4'd0, 2'd0, 16'd203, 1'b0));
      send_item(pack_item(OP_HELD, 3'd0, 4'd0, 2'd0, 16'd15, 1'b1));
      send_item(pack_item(OP_HELD, 3'd0, 4'd0, 2'd0, CODE_NONE, 1'b1));
      send_item(pack_item(OP_HELD, 3'd0, 4'd0, 2'd3, 16'd203, 1'b1));
      send_item(pack_item(OP_HELD, 3'd0, 4'd0, 2'd1, 16'hFFFF, 1'b1));
      send_item(pack_item(OP_LOAD, 3'd0, 4'd0, 2'd0, 16'hFFFF, 1'b0));
      send_item(pack_item(OP_LOAD, 3'd7, 4'd13, 2'd2, CODE_RSV_HI, 1'b0));
      send_item(pack_item(OP_LOAD, 3'd1, 4'd15, 2'd0, 16'd5, 1'b0));
      send_item(pack_item(OP_LOAD, 3'd1, 4'd0, 2'd3, 16'd5, 1'b0));
      send_item(pack_item(OP_REBIND, 3'd0, 4'd14, 2'd0, CODE_NONE, 1'b0));
      send_item(pack_item(OP_REBIND, 3'd0, 4'd0, 2'd0, CODE_NONE, 1'b0));
      send_item(pack_item(OP_REBIND, 3'd0, 4'd0, 2'd0, CODE_RSV_LO, 1'b0));
      send_item(pack_item(OP_REBIND, 3'd0, 4'd2, 2'd0, CODE_RSV_HI, 1'b0));
      send_item(pack_item(OP_INSTALL, 3'd0, 4'd0, 2'd0, CODE_NONE, 1'b0));
      send_item(pack_item(OP_REBIND, 3'd0, 4'd1, 2'd0, 16'hFFFF, 1'b0));
      send_item(pack_item(OP_HELD, 3'd0, 4'd0, 2'd0, 16'hFFFF, 1'b1));
      send_item(pack_item(OP_LOAD, 3'd7, 4'd5, 2'd1, 16'h8000, 1'b0));
      send_item(pack_item(OP_INSTALL, 3'd7, 4'd0, 2'd0, CODE_NONE, 1'b0));
      send_item(pack_item(OP_REBIND, 3'd7, 4'd6, 2'd1, 16'h8000, 1'b0));
      send_item(pack_item(OP_HELD, 3'd0, 4'd0, 2'd1, 16'h8000, 1'b0));
      send_item(pack_item(OP_HELD, 3'd0, 4'd0, 2'd2, CODE_RSV_HI, 1'b1));
      send_item(pack_item(OP_INSTALL, 3'd3, 4'd0, 2'd0, CODE_NONE, 1'b0));
      send_item(pack_item(OP_HELD, 3'd0, 4'd0, 2'd0, 16'd203, 1'b1));
      wait_drained();

      run_phase(115, 0, 0, 14'h3FFF, 0);
      run_phase(115, 57, 0, 14'($urandom), 0);
      run_phase(115, 0, 57, 14'h0000, 0);
      run_phase(115, 29, 29, 14'($urandom), 0);
      run_phase(115, 0, 0, 14'h3FFF, 160);
      run_phase(115, 0, 57, 14'($urandom), 0);

      repeat (64) @(posedge clock);
      $display("Covered %0d transfers, %0d results checked, %0d frames closed",
               board.transfers, board.checked, board.frames);
      $display("%0d items rejected by range or code checks, %0d repeat-mask settings",
               board.rejects, masks_written);
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/iam_pkg.sv
src/iam_ctrl.sv
src/iam_datapath.sv
src/input_action_mapper.sv
sim/tb_input_action_mapper.sv
